### src/rsla_pkg.sv
package rsla_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_BATTERY_ON    = 4'd0;
    localparam logic [3:0] CFG_BATTERY_OFF   = 4'd1;
    localparam logic [3:0] CFG_HEARTBEAT_ON  = 4'd2;
    localparam logic [3:0] CFG_HEARTBEAT_OFF = 4'd3;
    localparam logic [3:0] CFG_READY_ON      = 4'd4;
    localparam logic [3:0] CFG_READY_PERIOD  = 4'd5;
    localparam logic [3:0] CFG_FAST_TOGGLE   = 4'd6;
    localparam logic [3:0] CFG_MIN_LAP       = 4'd7;

    // Timer status codes
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_DISPLAY = 2'd2;
    localparam logic [1:0] TS_UNUSED  = 2'd3;

    // Battery color thresholds in percent
    localparam logic [6:0] PCT_RED_BELOW    = 7'd10;
    localparam logic [6:0] PCT_YELLOW_BELOW = 7'd20;
    localparam logic [6:0] PCT_VIOLET_BELOW = 7'd30;
    localparam logic [6:0] PCT_ORANGE_BELOW = 7'd50;

    // LED levels
    localparam logic [7:0] LEVEL_FULL   = 8'd255;
    localparam logic [7:0] LEVEL_ORANGE = 8'd140;
    localparam logic [7:0] LEVEL_OFF    = 8'd0;

    localparam logic [31:0] BEAM_TOGGLE_MS = 32'd500;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_BATTERY_ON    = 16'd500;
    localparam logic [15:0] RST_BATTERY_OFF   = 16'd500;
    localparam logic [15:0] RST_HEARTBEAT_ON  = 16'd100;
    localparam logic [15:0] RST_HEARTBEAT_OFF = 16'd2900;
    localparam logic [15:0] RST_READY_ON      = 16'd100;
    localparam logic [15:0] RST_READY_PERIOD  = 16'd1000;
    localparam logic [15:0] RST_FAST_TOGGLE   = 16'd100;
    localparam logic [23:0] RST_MIN_LAP       = 24'd5000;

    // Display window = min_lap / 1000 via reciprocal: ceil(2^34 / 1000),
    // exact for every 24-bit dividend.
    localparam int          DISP_SHIFT   = 34;
    localparam int          PROD_W       = 49;
    localparam int          WINDOW_W     = 15;
    localparam logic [24:0] DISP_RECIP   = 25'd17179870;
    localparam logic [14:0] RST_WINDOW   = 15'(RST_MIN_LAP / 1000);

    typedef struct packed {
        logic        lit;
        logic [31:0] mark;
    } blink_t;

    // Two-phase blink: lit for on_t, dark for off_t
    function automatic blink_t blink_step(input blink_t cur, input logic [31:0] now,
                                          input logic [31:0] on_t,
                                          input logic [31:0] off_t);
        blink_t      res;
        logic [31:0] el;
        res = cur;
        el  = now - cur.mark;
        if (cur.lit) begin
            if (el >= on_t) begin
                res.lit  = 1'b0;
                res.mark = now;
            end
        end else begin
            if (el >= off_t) begin
                res.lit  = 1'b1;
                res.mark = now;
            end
        end
        return res;
    endfunction

    // Flip lit once the interval has passed since the mark
    function automatic blink_t toggle_step(input blink_t cur, input logic [31:0] now,
                                           input logic [31:0] iv);
        blink_t res;
        res = cur;
        if ((now - cur.mark) >= iv) begin
            res.lit  = ~cur.lit;
            res.mark = now;
        end
        return res;
    endfunction

endpackage

### src/rgb_status_led_arbiter.sv
// RGB status LED arbiter.
// Input channel (s_valid/s_ready): one beat per update tick carrying the
// millisecond timestamp, battery percent, timer status, race time, display
// start time, beam-lost flag and sensor level.
// Result channel (m_valid/m_ready): one beat per tick with red and green PWM
// levels and the blue on bit.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; the user writes only while no tick is in flight, and the block does
// not enforce this. Unknown indexes are ignored. Pipeline: input register,
// then combinational evaluation, then the result register.
// Throughput: one tick per cycle unless the receiver stalls; the blink
// state is updated in the same cycle that writes the result register, so
// ticks run back to back. When the receiver stalls, the result register
// holds, the input register fills, and s_ready drops until the result beat
// is taken. Reset (aresetn low, synchronous) empties both registers, clears
// all blink state and loads the default timing values.
module rgb_status_led_arbiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic [6:0]  s_battery_percent,
    input  logic [1:0]  s_timer_status,
    input  logic [31:0] s_race_time_ms,
    input  logic [31:0] s_display_start_ms,
    input  logic        s_beam_lost,
    input  logic        s_sensor_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_level,
    output logic [7:0]  m_green_level,
    output logic        m_blue_on
);

    // Configuration registers
    logic [15:0] battery_on_reg, battery_off_reg, heartbeat_on_reg, heartbeat_off_reg;
    logic [15:0] ready_on_reg, ready_period_reg, fast_toggle_reg;
    logic [23:0] min_lap_reg;
    logic [rsla_pkg::WINDOW_W-1:0] window_reg;
    logic [rsla_pkg::PROD_W-1:0]   window_prod;

    // Input stage
    logic        stage_valid_reg;
    logic [31:0] in_now_reg, in_race_reg, in_disp_reg;
    logic [6:0]  in_pct_reg;
    logic [1:0]  in_status_reg;
    logic        in_beam_reg, in_sensor_reg;

    // Blink state
    rsla_pkg::blink_t bb_reg, hb_reg, op_reg, beam_reg;
    rsla_pkg::blink_t bb_next, hb_next, op_next, beam_next, op_clr;
    logic [1:0]  prev_status_reg;

    // Result register
    logic        m_valid_reg;
    logic [7:0]  red_reg, green_reg;
    logic        blue_reg;
    logic [7:0]  red_next, green_next;
    logic        blue_next;

    logic        out_free, advance;
    logic        healthy, is_yellow, is_violet, is_orange;
    logic [31:0] ready_off;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = stage_valid_reg && out_free;
    assign s_ready   = !stage_valid_reg || out_free;

    assign window_prod = rsla_pkg::PROD_W'(cfg_data) * rsla_pkg::PROD_W'(rsla_pkg::DISP_RECIP);

    // Write configuration registers; the display window is derived on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            battery_on_reg    <= rsla_pkg::RST_BATTERY_ON;
            battery_off_reg   <= rsla_pkg::RST_BATTERY_OFF;
            heartbeat_on_reg  <= rsla_pkg::RST_HEARTBEAT_ON;
            heartbeat_off_reg <= rsla_pkg::RST_HEARTBEAT_OFF;
            ready_on_reg      <= rsla_pkg::RST_READY_ON;
            ready_period_reg  <= rsla_pkg::RST_READY_PERIOD;
            fast_toggle_reg   <= rsla_pkg::RST_FAST_TOGGLE;
            min_lap_reg       <= rsla_pkg::RST_MIN_LAP;
            window_reg        <= rsla_pkg::RST_WINDOW;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rsla_pkg::CFG_BATTERY_ON:    battery_on_reg    <= cfg_data[15:0];
                rsla_pkg::CFG_BATTERY_OFF:   battery_off_reg   <= cfg_data[15:0];
                rsla_pkg::CFG_HEARTBEAT_ON:  heartbeat_on_reg  <= cfg_data[15:0];
                rsla_pkg::CFG_HEARTBEAT_OFF: heartbeat_off_reg <= cfg_data[15:0];
                rsla_pkg::CFG_READY_ON:      ready_on_reg      <= cfg_data[15:0];
                rsla_pkg::CFG_READY_PERIOD:  ready_period_reg  <= cfg_data[15:0];
                rsla_pkg::CFG_FAST_TOGGLE:   fast_toggle_reg   <= cfg_data[15:0];
                rsla_pkg::CFG_MIN_LAP: begin
                    min_lap_reg <= cfg_data;
                    window_reg  <= window_prod[rsla_pkg::PROD_W-1:rsla_pkg::DISP_SHIFT];
                end
                default: ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_now_reg    <= s_now_ms;
            in_pct_reg    <= s_battery_percent;
            in_status_reg <= s_timer_status;
            in_race_reg   <= s_race_time_ms;
            in_disp_reg   <= s_display_start_ms;
            in_beam_reg   <= s_beam_lost;
            in_sensor_reg <= s_sensor_level;
        end
    end

    assign ready_off = {16'd0, ready_period_reg} - {16'd0, ready_on_reg};

    // Evaluate one tick
    always_comb begin
        healthy   = in_pct_reg >= rsla_pkg::PCT_ORANGE_BELOW;
        is_yellow = in_pct_reg inside {[rsla_pkg::PCT_RED_BELOW :
                                        rsla_pkg::PCT_YELLOW_BELOW - 7'd1]};
        is_violet = in_pct_reg inside {[rsla_pkg::PCT_YELLOW_BELOW :
                                        rsla_pkg::PCT_VIOLET_BELOW - 7'd1]};
        is_orange = in_pct_reg inside {[rsla_pkg::PCT_VIOLET_BELOW :
                                        rsla_pkg::PCT_ORANGE_BELOW - 7'd1]};

        // battery path: one blink runs, the other is held dark at now
        if (healthy) begin
            bb_next.lit  = 1'b0;
            bb_next.mark = in_now_reg;
            hb_next = rsla_pkg::blink_step(hb_reg, in_now_reg, {16'd0, heartbeat_on_reg},
                                           {16'd0, heartbeat_off_reg});
        end else begin
            hb_next.lit  = 1'b0;
            hb_next.mark = in_now_reg;
            bb_next = rsla_pkg::blink_step(bb_reg, in_now_reg, {16'd0, battery_on_reg},
                                           {16'd0, battery_off_reg});
        end

        // operation path: restart on status change
        op_clr = op_reg;
        if (in_status_reg != prev_status_reg) begin
            op_clr.lit  = 1'b0;
            op_clr.mark = 32'd0;
        end
        op_next = op_clr;
        case (in_status_reg)
            rsla_pkg::TS_READY: begin
                op_next = rsla_pkg::blink_step(op_clr, in_now_reg, {16'd0, ready_on_reg},
                                               ready_off);
            end
            rsla_pkg::TS_RUNNING: begin
                if (in_race_reg < {8'd0, min_lap_reg}) begin
                    op_next = rsla_pkg::toggle_step(op_clr, in_now_reg,
                                                    {16'd0, fast_toggle_reg});
                end else begin
                    op_next.lit = 1'b1;
                end
            end
            rsla_pkg::TS_DISPLAY: begin
                if ((in_now_reg - in_disp_reg) < {17'd0, window_reg}) begin
                    op_next = rsla_pkg::toggle_step(op_clr, in_now_reg,
                                                    {16'd0, fast_toggle_reg});
                end else begin
                    op_next.lit = 1'b1;
                end
            end
            default: ;
        endcase

        // beam path: frozen while the beam is present
        beam_next = beam_reg;
        if (in_beam_reg) begin
            beam_next = rsla_pkg::toggle_step(beam_reg, in_now_reg, rsla_pkg::BEAM_TOGGLE_MS);
        end

        // arbitrate channels
        if (!healthy) begin
            red_next = bb_next.lit ? rsla_pkg::LEVEL_FULL : rsla_pkg::LEVEL_OFF;
        end else begin
            red_next = op_next.lit ? rsla_pkg::LEVEL_FULL : rsla_pkg::LEVEL_OFF;
        end
        green_next = rsla_pkg::LEVEL_OFF;
        if (bb_next.lit && is_yellow) begin
            green_next = rsla_pkg::LEVEL_FULL;
        end else if (bb_next.lit && is_orange) begin
            green_next = rsla_pkg::LEVEL_ORANGE;
        end
        if (in_beam_reg) begin
            blue_next = beam_next.lit;
        end else if (healthy) begin
            blue_next = hb_next.lit;
        end else if (is_violet) begin
            blue_next = bb_next.lit;
        end else begin
            blue_next = !in_sensor_reg;
        end
    end

    // Advance state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            bb_reg          <= '0;
            hb_reg          <= '0;
            op_reg          <= '0;
            beam_reg        <= '0;
            prev_status_reg <= rsla_pkg::TS_READY;
        end else begin
            if (out_free) begin
                m_valid_reg <= stage_valid_reg;
            end
            if (advance) begin
                bb_reg          <= bb_next;
                hb_reg          <= hb_next;
                op_reg          <= op_next;
                beam_reg        <= beam_next;
                prev_status_reg <= in_status_reg;
            end
        end
        if (advance) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_on     = blue_reg;

    // Input stage blocks only behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (stage_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !stage_valid_reg))
        else $error("pipeline not empty after reset");

    // Any green comes with full red
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && green_reg != rsla_pkg::LEVEL_OFF) |-> (red_reg == rsla_pkg::LEVEL_FULL))
        else $error("green lit without red");

    // A change into the unused status leaves the operation blink dark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_status_reg != prev_status_reg &&
         in_status_reg == rsla_pkg::TS_UNUSED) |=> !op_reg.lit)
        else $error("operation blink not cleared on status change");

endmodule
